// ===== design/htt_pkg.sv =====
`default_nettype none

package htt_pkg;

   localparam int HANDLE_W   = 16;
   localparam int NOW_W      = 32;
   localparam int EXPIRY_W   = 33;
   localparam int TIMEOUT_W  = 16;
   localparam int STATUS_W   = 3;
   localparam int MODE_W     = 2;
   localparam int OP_W       = 3;

   localparam int MAX_RESULTS = 16;
   localparam int NRES_W      = $clog2(MAX_RESULTS + 1);

   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd60;

   localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAN  = 2'd2;

   localparam logic [STATUS_W-1:0] ST_ADDED     = 3'd0;
   localparam logic [STATUS_W-1:0] ST_REFRESHED = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
   localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;
   localparam logic [STATUS_W-1:0] ST_EXPIRED   = 3'd5;
   localparam logic [STATUS_W-1:0] ST_NONE      = 3'd6;

   localparam logic [OP_W-1:0] CELL_HOLD    = 3'd0;
   localparam logic [OP_W-1:0] CELL_ADD     = 3'd1;
   localparam logic [OP_W-1:0] CELL_DELETE  = 3'd2;
   localparam logic [OP_W-1:0] CELL_COMPACT = 3'd3;
   localparam logic [OP_W-1:0] CELL_MARK    = 3'd4;
   localparam logic [OP_W-1:0] CELL_ROTATE  = 3'd5;

   typedef struct packed {
      logic                valid;
      logic                flag;
      logic [HANDLE_W-1:0] handle;
      logic [EXPIRY_W-1:0] expiry;
   } htt_entry_type;

   typedef struct packed {
      logic [OP_W-1:0]     op;
      logic                found;
      logic                keep;
      logic [HANDLE_W-1:0] handle;
      logic [EXPIRY_W-1:0] expiry;
      logic [NOW_W-1:0]    now_seconds;
      logic [HANDLE_W-1:0] rc_handle;
      logic [EXPIRY_W-1:0] rc_expiry;
   } htt_cmd_type;

endpackage

`default_nettype wire

// ===== design/htt_channels.sv =====
`default_nettype none

interface htt_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [15:0] handle;
   logic [31:0] now_seconds;

   modport source (output valid, output mode, output handle, output now_seconds,
                   input ready);
   modport sink (input valid, input mode, input handle, input now_seconds,
                 output ready);
endinterface

interface htt_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [15:0] result_handle;
   logic        last;

   modport source (output valid, output status, output result_handle, output last,
                   input ready);
   modport sink (input valid, input status, input result_handle, input last,
                 output ready);
endinterface

`default_nettype wire

// ===== design/htt_cell.sv =====
`default_nettype none

module htt_cell
   import htt_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire htt_cmd_type   cmd,
   input  wire logic          left_valid,
   input  wire htt_entry_type right,
   output htt_entry_type      entry,
   output logic               match,
   output logic               gap
);

   logic                valid_ff, valid_in;
   logic                flag_ff, flag_in;
   logic [HANDLE_W-1:0] handle_ff, handle_in;
   logic [EXPIRY_W-1:0] expiry_ff, expiry_in;

   assign match = valid_ff && (handle_ff == cmd.handle);
   assign gap   = !valid_ff && right.valid;

   always_comb begin
      entry.valid  = valid_ff;
      entry.flag   = flag_ff;
      entry.handle = handle_ff;
      entry.expiry = expiry_ff;
   end

   always_comb begin
      valid_in  = valid_ff;
      flag_in   = flag_ff;
      handle_in = handle_ff;
      expiry_in = expiry_ff;
      case (cmd.op)
         CELL_ADD: begin
            if (match) begin
               expiry_in = cmd.expiry;
            end else if (!cmd.found && !valid_ff && left_valid) begin
               valid_in  = 1'b1;
               flag_in   = 1'b0;
               handle_in = cmd.handle;
               expiry_in = cmd.expiry;
            end
         end
         CELL_DELETE: begin
            if (match) begin
               valid_in = 1'b0;
               flag_in  = 1'b0;
            end
         end
         CELL_COMPACT: begin
            // hole moves one cell toward the tail each cycle
            if (!valid_ff) begin
               valid_in  = right.valid;
               flag_in   = 1'b0;
               handle_in = right.handle;
               expiry_in = right.expiry;
            end else if (!left_valid) begin
               valid_in = 1'b0;
               flag_in  = 1'b0;
            end
         end
         CELL_MARK: begin
            flag_in = valid_ff && (expiry_ff <= {1'b0, cmd.now_seconds});
         end
         CELL_ROTATE: begin
            if (right.valid) begin
               valid_in  = 1'b1;
               flag_in   = right.flag;
               handle_in = right.handle;
               expiry_in = right.expiry;
            end else if (valid_ff) begin
               // tail takes the entry leaving the head unless it was emitted
               valid_in  = cmd.keep;
               flag_in   = 1'b0;
               handle_in = cmd.rc_handle;
               expiry_in = cmd.rc_expiry;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         flag_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         flag_ff  <= flag_in;
      end
      handle_ff <= handle_in;
      expiry_ff <= expiry_in;
   end

endmodule

`default_nettype wire

// ===== design/handle_timeout_table.sv =====
// handle_timeout_table: table of handles with expiry times, kept in insertion order.
// requests arrive on req_ch (mode, handle, now_seconds) and are taken when valid
// and ready are both high; ready is high only while the sequencer is idle.
// results leave on rsp_ch (status, result_handle, last) from an output register;
// last marks the final result of a request.
// csr_timeout_seconds is written whenever csr_valid is high (csr_ready is tied
// high); a zero write is ignored. the timeout resets to 60 seconds.
// storage is a row of CAPACITY cells, each shifting to its neighbor.
// add: the exec state decides the result by a parallel handle match in every cell.
// delete: the result is decided in the exec state, then the gap closes one cell per
// cycle, and the next request is taken once no gap is left.
// clean: expired flags are marked, then the table rotates through cell 0 once, one
// entry per cycle unless an expired head waits for the output register, emitting
// up to MAX_RESULTS expired entries as they pass, or a none result if none expired.
// a stalled receiver holds the output register, and the sequencer waits in
// place until the register frees up; no result is lost or repeated.
// synchronous reset empties the table and returns the sequencer to idle.
`default_nettype none

module handle_timeout_table
   import htt_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   htt_req_if.sink                   req_ch,
   htt_rsp_if.source                 rsp_ch,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [TIMEOUT_W-1:0] csr_timeout_seconds
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_EXEC    = 3'd1;
   localparam logic [2:0] S_COMPACT = 3'd2;
   localparam logic [2:0] S_MARK    = 3'd3;
   localparam logic [2:0] S_ROTATE  = 3'd4;

   logic [2:0]           state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     rot_ff, rot_in;
   logic [NRES_W-1:0]    n_ff, n_in;
   logic [TIMEOUT_W-1:0] timeout_ff;

   logic [MODE_W-1:0]    op_mode_ff;
   logic [HANDLE_W-1:0]  op_handle_ff;
   logic [NOW_W-1:0]     op_now_ff;
   logic [EXPIRY_W-1:0]  op_expiry_ff;

   logic                 rsp_valid_ff;
   logic [STATUS_W-1:0]  rsp_status_ff;
   logic [HANDLE_W-1:0]  rsp_handle_ff;
   logic                 rsp_last_ff;

   logic                 emit;
   logic [STATUS_W-1:0]  emit_status;
   logic [HANDLE_W-1:0]  emit_handle;
   logic                 emit_last;

   htt_cmd_type          cmd;
   htt_entry_type        cell_q [CAPACITY];
   htt_entry_type        right_q [CAPACITY];
   logic [CAPACITY-1:0]  left_valid;
   logic [CAPACITY-1:0]  match_vec, gap_vec, valid_vec, flag_vec, rest_vec;

   logic                 req_fire, out_free, found_any, full, head_exp;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign found_any    = |match_vec;
   assign full         = (count_ff == CNT_W'(CAPACITY));
   assign csr_ready    = 1'b1;

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      if (g == 0) begin : g_head
         assign left_valid[g] = 1'b1;
      end else begin : g_mid
         assign left_valid[g] = cell_q[g-1].valid;
      end
      if (g == CAPACITY - 1) begin : g_tail
         assign right_q[g] = '0;
      end else begin : g_body
         assign right_q[g] = cell_q[g+1];
      end
      assign valid_vec[g] = cell_q[g].valid;
      assign flag_vec[g]  = cell_q[g].flag;
      assign rest_vec[g]  = (g != 0) && cell_q[g].flag;

      htt_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .left_valid (left_valid[g]),
         .right      (right_q[g]),
         .entry      (cell_q[g]),
         .match      (match_vec[g]),
         .gap        (gap_vec[g])
      );
   end

   assign head_exp = cell_q[0].flag && (n_ff != NRES_W'(MAX_RESULTS));

   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      rot_in          = rot_ff;
      n_in            = n_ff;
      cmd.op          = CELL_HOLD;
      cmd.found       = found_any;
      cmd.keep        = 1'b1;
      cmd.handle      = op_handle_ff;
      cmd.expiry      = op_expiry_ff;
      cmd.now_seconds = op_now_ff;
      cmd.rc_handle   = cell_q[0].handle;
      cmd.rc_expiry   = cell_q[0].expiry;
      emit            = 1'b0;
      emit_status     = ST_ADDED;
      emit_handle     = op_handle_ff;
      emit_last       = 1'b1;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req_ch.mode)
                  MODE_ADD, MODE_DELETE: state_in = S_EXEC;
                  MODE_CLEAN:            state_in = S_MARK;
                  default:               state_in = S_IDLE;
               endcase
            end
         end
         S_EXEC: begin
            if (out_free) begin
               emit = 1'b1;
               if (op_mode_ff == MODE_ADD) begin
                  cmd.op   = CELL_ADD;
                  state_in = S_IDLE;
                  if (found_any) begin
                     emit_status = ST_REFRESHED;
                  end else if (full) begin
                     emit_status = ST_FULL;
                  end else begin
                     emit_status = ST_ADDED;
                     count_in    = count_ff + CNT_W'(1);
                  end
               end else begin
                  cmd.op = CELL_DELETE;
                  if (found_any) begin
                     emit_status = ST_DELETED;
                     count_in    = count_ff - CNT_W'(1);
                     state_in    = S_COMPACT;
                  end else begin
                     emit_status = ST_NOT_FOUND;
                     state_in    = S_IDLE;
                  end
               end
            end
         end
         S_COMPACT: begin
            if (|gap_vec) begin
               cmd.op = CELL_COMPACT;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_MARK: begin
            cmd.op   = CELL_MARK;
            rot_in   = count_ff;
            n_in     = '0;
            state_in = S_ROTATE;
         end
         S_ROTATE: begin
            if ((n_ff == '0) && !(|flag_vec)) begin
               if (out_free) begin
                  emit        = 1'b1;
                  emit_status = ST_NONE;
                  emit_handle = '0;
                  emit_last   = 1'b1;
                  state_in    = S_IDLE;
               end
            end else if (rot_ff == '0) begin
               state_in = S_IDLE;
            end else if (!head_exp || out_free) begin
               cmd.op   = CELL_ROTATE;
               cmd.keep = !head_exp;
               rot_in   = rot_ff - CNT_W'(1);
               if (head_exp) begin
                  emit        = 1'b1;
                  emit_status = ST_EXPIRED;
                  emit_handle = cell_q[0].handle;
                  emit_last   = !(|rest_vec) || (n_ff == NRES_W'(MAX_RESULTS - 1));
                  n_in        = n_ff + NRES_W'(1);
                  count_in    = count_ff - CNT_W'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rot_ff       <= '0;
         n_ff         <= '0;
         timeout_ff   <= TIMEOUT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rot_ff   <= rot_in;
         n_ff     <= n_in;
         if (csr_valid && (csr_timeout_seconds != '0)) begin
            timeout_ff <= csr_timeout_seconds;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (req_fire) begin
         op_mode_ff   <= req_ch.mode;
         op_handle_ff <= req_ch.handle;
         op_now_ff    <= req_ch.now_seconds;
         op_expiry_ff <= {1'b0, req_ch.now_seconds} + EXPIRY_W'(timeout_ff);
      end
      if (emit) begin
         rsp_status_ff <= emit_status;
         rsp_handle_ff <= emit_handle;
         rsp_last_ff   <= emit_last;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.status        = rsp_status_ff;
   assign rsp_ch.result_handle = rsp_handle_ff;
   assign rsp_ch.last          = rsp_last_ff;

   // occupied cells always agree with the entry count
   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == int'(count_ff))
      else $error("cell occupancy differs from entry count");

   a_no_gap_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !(|gap_vec))
      else $error("table has a gap while idle");

   a_unique_match: assert property (@(posedge clock) disable iff (reset)
      $onehot0(match_vec))
      else $error("handle stored more than once");

   a_emit_bound: assert property (@(posedge clock) disable iff (reset)
      n_ff <= NRES_W'(MAX_RESULTS))
      else $error("too many expired results in one clean");

   a_rotate_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROTATE && rot_ff == '0 && n_ff != '0) |=> (state_ff == S_IDLE))
      else $error("clean did not finish after full rotation");

endmodule

`default_nettype wire

// ===== test/handle_timeout_table_test.sv =====
module handle_timeout_table_test;
   import htt_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAPACITY = 16;
   localparam int SETTLE_CYCLES = CAPACITY + 8;
   localparam int CYCLE_LIMIT = 500000;
   localparam int PHASE_REQUESTS = 60;
   localparam logic [MODE_W-1:0] MODE_IGNORED = 2'd3;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [HANDLE_W-1:0] handle;
      logic                last;
   } table_result_type;

   // mirror of the handle table, predicting every result of each request
   class timeout_table_model;
      logic [TIMEOUT_W-1:0] timeout;
      logic [HANDLE_W-1:0]  handles[CAPACITY];
      logic [EXPIRY_W-1:0]  expiries[CAPACITY];
      int                   fill;
      table_result_type     expected_results[$];
      int                   failures;
      int                   requests;
      int                   results;
      int                   status_seen[8];

      function new();
         timeout = TIMEOUT_RESET;
         fill = 0;
         failures = 0;
         requests = 0;
         results = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
      endfunction

      function void write_timeout(logic [TIMEOUT_W-1:0] value);
         if (value != '0) timeout = value;
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      function void push_result(logic [STATUS_W-1:0] status, logic [HANDLE_W-1:0] handle,
                                logic last);
         table_result_type r;
         r.status = status;
         r.handle = handle;
         r.last = last;
         expected_results.push_back(r);
      endfunction

      // close the gap left at pos
      function void remove_entry(int pos);
         for (int i = pos; i + 1 < fill; i++) begin
            handles[i] = handles[i + 1];
            expiries[i] = expiries[i + 1];
         end
         fill--;
      endfunction

      function void apply_request(logic [MODE_W-1:0] mode, logic [HANDLE_W-1:0] handle,
                                  logic [NOW_W-1:0] now);
         logic [EXPIRY_W-1:0] expiry;
         table_result_type    tail;
         int                  pos;
         int                  hits;
         bit                  found;
         found = 0;
         case (mode)
            MODE_ADD: begin
               requests++;
               expiry = {1'b0, now} + EXPIRY_W'(timeout);
               for (int i = 0; i < fill; i++) begin
                  if (!found && handles[i] == handle) begin
                     expiries[i] = expiry;
                     found = 1;
                  end
               end
               if (found) begin
                  push_result(ST_REFRESHED, handle, 1'b1);
               end else if (fill >= CAPACITY) begin
                  push_result(ST_FULL, handle, 1'b1);
               end else begin
                  handles[fill] = handle;
                  expiries[fill] = expiry;
                  fill++;
                  push_result(ST_ADDED, handle, 1'b1);
               end
            end
            MODE_DELETE: begin
               requests++;
               pos = -1;
               for (int i = 0; i < fill; i++) begin
                  if (pos < 0 && handles[i] == handle) pos = i;
               end
               if (pos >= 0) begin
                  remove_entry(pos);
                  push_result(ST_DELETED, handle, 1'b1);
               end else begin
                  push_result(ST_NOT_FOUND, handle, 1'b1);
               end
            end
            MODE_CLEAN: begin
               requests++;
               pos = 0;
               hits = 0;
               while (pos < fill && hits < MAX_RESULTS) begin
                  if (expiries[pos] <= {1'b0, now}) begin
                     push_result(ST_EXPIRED, handles[pos], 1'b0);
                     hits++;
                     remove_entry(pos);
                  end else begin
                     pos++;
                  end
               end
               if (hits == 0) begin
                  push_result(ST_NONE, '0, 1'b1);
               end else begin
                  tail = expected_results.pop_back();
                  tail.last = 1'b1;
                  expected_results.push_back(tail);
               end
            end
            default: ;
         endcase
      endfunction

      function void check_result(logic [STATUS_W-1:0] status, logic [HANDLE_W-1:0] handle,
                                 logic last);
         table_result_type want;
         results++;
         if (expected_results.size() == 0) begin
            $error("result with no request outstanding: status %0d handle %0d last %0d",
                   status, handle, last);
            failures++;
            return;
         end
         want = expected_results.pop_front();
         status_seen[want.status]++;
         if (status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            failures++;
         end
         if (handle !== want.handle) begin
            $error("result_handle: expected %0d, actual %0d", want.handle, handle);
            failures++;
         end
         if (last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, last);
            failures++;
         end
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [TIMEOUT_W-1:0] csr_timeout_seconds;
   bit                   steady = 1'b0;
   logic [NOW_W-1:0]     clock_seconds;
   int                   cycle_count = 0;
   timeout_table_model   model = new();

   htt_req_if req_ch();
   htt_rsp_if rsp_ch();

   handle_timeout_table #(.CAPACITY(CAPACITY)) u_top (
      .clock               (clock),
      .reset               (reset),
      .req_ch              (req_ch),
      .rsp_ch              (rsp_ch),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_timeout_seconds (csr_timeout_seconds)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("handle_timeout_table verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready)
            model.check_result(rsp_ch.status, rsp_ch.result_handle, rsp_ch.last);
         if (req_ch.valid && req_ch.ready)
            model.apply_request(req_ch.mode, req_ch.handle, req_ch.now_seconds);
      end
   end

   // receiver stalls
   always @(negedge clock) begin
      rsp_ch.ready = steady || ($urandom_range(0, 99) >= 21);
   end

   task automatic send_request(input logic [MODE_W-1:0] mode, input logic [HANDLE_W-1:0] handle,
                               input logic [NOW_W-1:0] now);
      @(negedge clock);
      while (!steady && $urandom_range(0, 99) < 21) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid = 1'b1;
      req_ch.mode = mode;
      req_ch.handle = handle;
      req_ch.now_seconds = now;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (model.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_timeout(input logic [TIMEOUT_W-1:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_timeout_seconds = value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      model.write_timeout(value);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic random_request(output bit counted);
      logic [MODE_W-1:0]   mode;
      logic [HANDLE_W-1:0] handle;
      int                  roll;
      roll = $urandom_range(0, 99);
      if (roll < 5) mode = MODE_IGNORED;
      else if (roll < 55) mode = MODE_ADD;
      else if (roll < 77) mode = MODE_DELETE;
      else mode = MODE_CLEAN;
      // a small handle pool keeps hits and a full table likely
      if ($urandom_range(0, 99) < 85) handle = HANDLE_W'($urandom_range(0, 19));
      else handle = HANDLE_W'($urandom);
      roll = $urandom_range(0, 99);
      if (roll < 4) clock_seconds = $urandom;
      else if (roll < 6) clock_seconds = 32'hFFFF_FFFF - NOW_W'($urandom_range(0, 3));
      else clock_seconds = clock_seconds + NOW_W'($urandom_range(0, model.timeout / 3 + 1));
      send_request(mode, handle, clock_seconds);
      counted = (mode != MODE_IGNORED);
   endtask

   initial begin
      logic [TIMEOUT_W-1:0] setting;
      int                   done;
      bit                   counted;
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_timeout_seconds = '0;
      req_ch.valid = 1'b0;
      req_ch.mode = MODE_ADD;
      req_ch.handle = '0;
      req_ch.now_seconds = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed requests under the reset timeout
      send_request(MODE_CLEAN, 16'h0000, 32'd0);
      send_request(MODE_DELETE, 16'h1234, 32'd0);
      send_request(MODE_ADD, 16'h0000, 32'd0);
      send_request(MODE_ADD, 16'hFFFF, 32'hFFFF_FFFF);
      send_request(MODE_ADD, 16'h0000, 32'd5);
      send_request(MODE_IGNORED, 16'hFFFF, 32'hFFFF_FFFF);
      for (int h = 1; h <= 14; h++) send_request(MODE_ADD, HANDLE_W'(h), 32'd0);
      send_request(MODE_ADD, 16'h8000, 32'd0);
      send_request(MODE_DELETE, 16'd7, 32'd0);
      send_request(MODE_CLEAN, 16'hFFFF, 32'd64);
      send_request(MODE_CLEAN, 16'h0000, 32'hFFFF_FFFF);
      send_request(MODE_CLEAN, 16'h0000, 32'd60);

      clock_seconds = 32'd1000;
      for (int phase = 0; phase < 6; phase++) begin
         wait_for_results();
         case (phase)
            0: setting = 16'd1;
            1: setting = 16'hFFFF;
            2: setting = 16'd0;
            3: setting = 16'd5;
            4: setting = TIMEOUT_W'($urandom_range(2, 65534));
            default: setting = TIMEOUT_RESET;
         endcase
         write_timeout(setting);
         steady = (phase == 2);
         done = 0;
         while (done < PHASE_REQUESTS) begin
            random_request(counted);
            if (counted) begin
               done++;
               if (phase == 3 && done == PHASE_REQUESTS / 2) wait_for_results();
            end
         end
      end
      steady = 1'b0;
      wait_for_results();

      $display("covered %0d requests and %0d results over six timeout settings",
               model.requests, model.results);
      $display("expired %0d, full drops %0d, refreshes %0d, deletes %0d, empty cleans %0d",
               model.status_seen[ST_EXPIRED], model.status_seen[ST_FULL],
               model.status_seen[ST_REFRESHED], model.status_seen[ST_DELETED],
               model.status_seen[ST_NONE]);
      if (model.failures == 0) begin
         $display("handle_timeout_table verification clean");
      end else begin
         $display("handle_timeout_table verification failed");
      end
      $finish;
   end

endmodule
